// ----- rtl/assert_macros.svh -----
// Assertion macros used by the tracker engine (ict_engine).
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset
`define ICT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included
`define ICT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ict_pkg.sv -----
// Shared types and constants of the in-flight collision tracker.
// No dependencies; used by ict_ram, ict_engine and the top level.
package ict_pkg;

  localparam int unsigned CHANNELS_DEF            = 8;
  localparam int unsigned ENTRIES_PER_CHANNEL_DEF = 16;
  localparam int unsigned KEY_W                   = 32;
  localparam int unsigned COUNT_W                 = 32;
  localparam int unsigned CHAN_IN_W               = 3;

  // Transaction op codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [CHAN_IN_W-1:0] channel;
    logic [KEY_W-1:0]     packet_key;
    logic                 base_valid;
    logic                 is_safety;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] collision_total;
    logic               overflow;
  } out_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic             valid;
    logic             collided;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

// ----- rtl/ict_ram.sv -----
// Single-port-write, single-port-read table memory with registered read data.
// Depends on ict_pkg for the entry type.
module ict_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ict_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output ict_pkg::entry_t rdata_o
);
  import ict_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ict_engine.sv -----
// Sequencer of the tracker: clearing pass, channel scan, read-modify-write of
// the table memory, collision counter and output register. Uses ict_pkg.
`include "assert_macros.svh"

module ict_engine #(
  parameter int unsigned CHANNELS            = 8,
  parameter int unsigned ENTRIES_PER_CHANNEL = 16,
  parameter int unsigned CW                  = 3,
  parameter int unsigned SW                  = 4,
  parameter int unsigned DEPTH               = 128,
  parameter int unsigned AW                  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            multichannel_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ict_pkg::in_t    in_data_i,
  input  logic [CW-1:0]   chan_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ict_pkg::out_t   out_data_o,
  output logic            ram_we_o,
  output logic [AW-1:0]   ram_waddr_o,
  output ict_pkg::entry_t ram_wdata_o,
  output logic [AW-1:0]   ram_raddr_o,
  input  ict_pkg::entry_t ram_rdata_i
);
  import ict_pkg::*;

  localparam logic [SW:0] ENTRIES = (SW+1)'(ENTRIES_PER_CHANNEL);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_MARK   = 7'b0001000,
    ST_INSERT = 7'b0010000,
    ST_REMOVE = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  // Captured transaction
  logic               op_q, op_d;
  logic [CW-1:0]      chan_q, chan_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic               safety_q, safety_d;

  // Scan bookkeeping
  logic [SW:0]        iss_q, iss_d;
  logic               rv_q, rv_d;
  logic [SW-1:0]      rs_q, rs_d;
  logic [SW:0]        vcnt_q, vcnt_d;
  logic               fv_found_q, fv_found_d;
  logic [SW-1:0]      fv_slot_q, fv_slot_d;
  logic [KEY_W-1:0]   fv_key_q, fv_key_d;
  logic               ff_found_q, ff_found_d;
  logic [SW-1:0]      ff_slot_q, ff_slot_d;
  logic               m_found_q, m_found_d;
  logic [SW-1:0]      m_slot_q, m_slot_d;
  logic               m_coll_q, m_coll_d;

  // Result and counter
  logic               acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [COUNT_W-1:0] coll_q, coll_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               scan_done;
  logic               need_insert;

  assign scan_done   = (iss_q == ENTRIES) && !rv_q;
  assign need_insert = !m_found_q && (vcnt_q < ENTRIES);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    chan_d      = chan_q;
    key_d       = key_q;
    safety_d    = safety_q;
    iss_d       = iss_q;
    rv_d        = 1'b0;
    rs_d        = rs_q;
    vcnt_d      = vcnt_q;
    fv_found_d  = fv_found_q;
    fv_slot_d   = fv_slot_q;
    fv_key_d    = fv_key_q;
    ff_found_d  = ff_found_q;
    ff_slot_d   = ff_slot_q;
    m_found_d   = m_found_q;
    m_slot_d    = m_slot_q;
    m_coll_d    = m_coll_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    coll_d      = coll_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = clr_q;
    ram_wdata_o = '0;
    ram_raddr_o = AW'({chan_q, iss_q[SW-1:0]});

    unique case (state_q)
      // Sweep the whole table to empty entries
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        clr_d    = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      // Take a transaction and start the channel scan
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_data_i.op;
          chan_d     = chan_i;
          key_d      = in_data_i.packet_key;
          safety_d   = in_data_i.is_safety;
          iss_d      = '0;
          vcnt_d     = '0;
          fv_found_d = 1'b0;
          ff_found_d = 1'b0;
          m_found_d  = 1'b0;
          m_coll_d   = 1'b0;
          acc_d      = 1'b0;
          ovf_d      = 1'b0;
          if (in_data_i.op == OP_END && !in_data_i.base_valid) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // Issue one read per cycle; evaluate the entry whose read was issued in the previous cycle
      ST_SCAN: begin
        if (iss_q < ENTRIES) begin
          rv_d  = 1'b1;
          rs_d  = iss_q[SW-1:0];
          iss_d = iss_q + (SW+1)'(1);
        end
        if (rv_q) begin
          if (ram_rdata_i.valid) begin
            vcnt_d = vcnt_q + (SW+1)'(1);
            if (!fv_found_q) begin
              fv_found_d = 1'b1;
              fv_slot_d  = rs_q;
              fv_key_d   = ram_rdata_i.key;
            end
            if (!m_found_q && ram_rdata_i.key == key_q) begin
              m_found_d = 1'b1;
              m_slot_d  = rs_q;
              m_coll_d  = ram_rdata_i.collided;
            end
          end else if (!ff_found_q) begin
            ff_found_d = 1'b1;
            ff_slot_d  = rs_q;
          end
        end
        if (scan_done) begin
          if (op_q == OP_BEGIN) begin
            acc_d = 1'b1;
            ovf_d = !m_found_q && (vcnt_q >= ENTRIES);
            if (vcnt_q == (SW+1)'(1)) begin
              state_d = ST_MARK;
            end else if (need_insert) begin
              state_d = ST_INSERT;
            end else begin
              state_d = ST_RESP;
            end
          end else if (m_found_q) begin
            acc_d = !m_coll_q;
            if (m_coll_q && (!multichannel_i || safety_q) && (coll_q != '1)) begin
              coll_d = coll_q + COUNT_W'(1);
            end
            state_d = ST_REMOVE;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      // Mark the single in-flight packet collided
      ST_MARK: begin
        ram_we_o             = 1'b1;
        ram_waddr_o          = AW'({chan_q, fv_slot_q});
        ram_wdata_o.valid    = 1'b1;
        ram_wdata_o.collided = 1'b1;
        ram_wdata_o.key      = fv_key_q;
        state_d              = need_insert ? ST_INSERT : ST_RESP;
      end

      // Insert the new key in the first free slot
      ST_INSERT: begin
        ram_we_o             = 1'b1;
        ram_waddr_o          = AW'({chan_q, ff_slot_q});
        ram_wdata_o.valid    = 1'b1;
        ram_wdata_o.collided = (vcnt_q != '0);
        ram_wdata_o.key      = key_q;
        state_d              = ST_RESP;
      end

      // Drop the finished packet
      ST_REMOVE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'({chan_q, m_slot_q});
        state_d     = ST_RESP;
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.accepted        = acc_q;
          out_d.collision_total = coll_q;
          out_d.overflow        = ovf_q;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      iss_q       <= '0;
      rv_q        <= 1'b0;
      vcnt_q      <= '0;
      fv_found_q  <= 1'b0;
      ff_found_q  <= 1'b0;
      m_found_q   <= 1'b0;
      coll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      rv_q        <= rv_d;
      vcnt_q      <= vcnt_d;
      fv_found_q  <= fv_found_d;
      ff_found_q  <= ff_found_d;
      m_found_q   <= m_found_d;
      coll_q      <= coll_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    chan_q    <= chan_d;
    key_q     <= key_d;
    safety_q  <= safety_d;
    rs_q      <= rs_d;
    fv_slot_q <= fv_slot_d;
    fv_key_q  <= fv_key_d;
    ff_slot_q <= ff_slot_d;
    m_slot_q  <= m_slot_d;
    m_coll_q  <= m_coll_d;
    acc_q     <= acc_d;
    ovf_q     <= ovf_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ICT_ASSERT(a_count_monotonic, 1'b1 |=> (coll_q >= $past(coll_q)), "collision count decreased")
  `ICT_ASSERT(a_occupancy_bound, vcnt_q <= ENTRIES, "scan counted too many entries")
  `ICT_ASSERT_ALWAYS(a_no_write_in_scan, (state_q == ST_SCAN) |-> !ram_we_o, "table write during scan")
  `ICT_ASSERT(a_valid_write_src, (ram_we_o && ram_wdata_o.valid) |-> (state_q == ST_MARK || state_q == ST_INSERT), "live entry written outside mark or insert")

endmodule

// ----- rtl/inflight_collision_tracker.sv -----
// In-flight collision tracker: top level with configuration register and
// channel mapping. Instantiates ict_engine and ict_ram; uses ict_pkg.
//
// After reset the block sweeps all CHANNELS * 2^ceil(log2(ENTRIES_PER_CHANNEL))
// entries of its table (128 with the defaults) and takes no transaction until
// done; the configuration port is always ready. Each transaction reads every
// entry of its channel from the table memory, one read per cycle on its single
// read port, then writes back up to two entries before its result is handed
// to the output register. An end transaction whose upstream check failed
// skips the scan and goes straight to the result step. One transaction is in
// work at a time; a new one is accepted while the previous result waits in
// the output register, and a transaction holds in its last step while that
// register is still occupied.
module inflight_collision_tracker #(
  parameter int unsigned CHANNELS            = ict_pkg::CHANNELS_DEF,
  parameter int unsigned ENTRIES_PER_CHANNEL = ict_pkg::ENTRIES_PER_CHANNEL_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ict_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ict_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import ict_pkg::*;

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW    = $clog2(ENTRIES_PER_CHANNEL);
  localparam int unsigned DEPTH = CHANNELS * (2 ** SW);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          multichannel_q;
  logic [6:0]    chan_mod;
  logic [CW-1:0] chan;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multichannel_q <= 1'b0;
    end else if (cfg_valid_i) begin
      multichannel_q <= cfg_data_i;
    end
  end

  // Fold the incoming channel onto the table count
  always_comb begin
    chan_mod = {4'b0000, in_data_i.channel};
    for (int i = 0; i < 8; i++) begin
      if (chan_mod >= 7'(CHANNELS)) begin
        chan_mod = chan_mod - 7'(CHANNELS);
      end
    end
  end

  assign chan = multichannel_q ? chan_mod[CW-1:0] : '0;

  ict_engine #(
    .CHANNELS           (CHANNELS),
    .ENTRIES_PER_CHANNEL(ENTRIES_PER_CHANNEL),
    .CW                 (CW),
    .SW                 (SW),
    .DEPTH              (DEPTH),
    .AW                 (AW)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .multichannel_i(multichannel_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .chan_i        (chan),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  ict_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
